FILE: hw/rtl/cmil_pkg.sv
`default_nettype none

package cmil_pkg;

  // number of colour steps; each table holds one entry more
  localparam int COLOURS = 64;
  localparam int DEPTH   = COLOURS + 1;
  localparam int ADDR_W  = $clog2(DEPTH);
  // luma * COLOURS stays below 256 * COLOURS
  localparam int POS_W   = 8 + $clog2(COLOURS);

  localparam int ENTRY_W = 16;
  localparam int CHAN_W  = 8;
  localparam int FRAC_W  = 8;

  typedef enum logic {
    OP_PIXEL       = 1'b0,
    OP_TABLE_WRITE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2,
    CH_NONE  = 2'd3
  } chan_t;

  // the two neighbouring entries and the fraction for one channel
  typedef struct packed {
    logic [ENTRY_W-1:0] e0;
    logic [ENTRY_W-1:0] e1;
    logic [FRAC_W-1:0]  fr;
  } interp_in_t;

endpackage

`default_nettype wire

FILE: hw/rtl/colour_map_interpolating_lut_unit.sv
`default_nettype none
// a pixel beat passes the ram read stage and the output register on its way to out_tvalid
// throughput: one beat per clock, pixel or table write, unless the output stalls;
// table writes give no output beat; the tables sit in three dual-read synchronous rams,
// both neighbours read in the same cycle; reset clears the pipeline valids and invert;
// table contents are kept and hold garbage until written

module colour_map_interpolating_lut_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,   // invert
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // luma[7:0], alpha_in[15:8], table_channel[17:16], table_index[24:18],
  // table_value[40:25], zero fill above
  input  wire logic [47:0] in_tdata,
  input  wire logic        in_tuser,      // operation
  input  wire logic        in_tlast,      // last_in_frame
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // red[7:0], green[15:8], blue[23:16], alpha_out[31:24]
  output logic      [31:0] out_tdata,
  output logic             out_tlast      // frame_end
);

  import cmil_pkg::*;

  logic              invert_r;
  logic              in_acc;
  op_t               op;
  chan_t             tchan;
  logic [7:0]        luma_eff;
  logic [POS_W-1:0]  pos;
  logic [ADDR_W-1:0] rd_idx0;
  logic [ADDR_W-1:0] rd_idx1;
  logic              rd_en;
  logic              tab_wr;
  logic [ADDR_W-1:0] wr_addr;
  logic [2:0]        wr_en;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [FRAC_W-1:0] s1_fr_r;
  logic [7:0]        s1_alpha_r;
  logic              s1_last_r;
  logic              s1_adv;

  logic [ENTRY_W-1:0] e0 [3];
  logic [ENTRY_W-1:0] e1 [3];
  logic [CHAN_W-1:0]  chan_val [3];

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [31:0]       out_data_r;
  logic              out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
    end else if (cfg_wr_en) begin
      invert_r <= cfg_wr_data;
    end
  end

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);
  assign tchan     = chan_t'(in_tdata[17:16]);

  always_comb begin
    luma_eff = invert_r ? ~in_tdata[7:0] : in_tdata[7:0];
    pos      = POS_W'(luma_eff) * POS_W'(COLOURS);
    rd_idx0  = ADDR_W'(pos >> 8);
    rd_idx1  = rd_idx0 + ADDR_W'(1);
  end

  assign rd_en   = in_acc && (op == OP_PIXEL);
  assign tab_wr  = in_acc && (op == OP_TABLE_WRITE) && ({1'b0, in_tdata[24:18]} < 8'(DEPTH));
  assign wr_addr = ADDR_W'(in_tdata[24:18]);
  assign wr_en[0] = tab_wr && (tchan == CH_RED);
  assign wr_en[1] = tab_wr && (tchan == CH_GREEN);
  assign wr_en[2] = tab_wr && (tchan == CH_BLUE);

  // a write and a read never share an edge, so a pixel always sees earlier writes
  for (genvar c = 0; c < 3; c++) begin : g_chan
    interp_in_t ii;

    cmil_ram #(
      .DATA_W (ENTRY_W),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
    ) u_ram (
      .clk       (clk),
      .wr_en     (wr_en[c]),
      .wr_addr   (wr_addr),
      .wr_data   (in_tdata[40:25]),
      .rd_en     (rd_en),
      .rd_addr_a (rd_idx0),
      .rd_addr_b (rd_idx1),
      .rd_data_a (e0[c]),
      .rd_data_b (e1[c])
    );

    assign ii = '{e0: e0[c], e1: e1[c], fr: s1_fr_r};

    cmil_interp u_interp (
      .in   (ii),
      .chan (chan_val[c])
    );
  end

  // stage 1: ram read data plus pixel sideband
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) begin
      s1_valid_nxt = rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_fr_r    <= pos[FRAC_W-1:0];
      s1_alpha_r <= in_tdata[15:8];
      s1_last_r  <= in_tlast;
    end
  end

  // stage 2: output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_data_r <= {s1_alpha_r, chan_val[2], chan_val[1], chan_val[0]};
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // a table write never leaves a beat in the data stage
  a_write_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (op == OP_TABLE_WRITE) |=> !s1_valid_r)
    else $error("table write produced a pixel beat");

  // an accepted pixel always lands in the data stage
  a_pixel_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (op == OP_PIXEL) |=> s1_valid_r)
    else $error("accepted pixel lost");

  // a waiting pixel is held while the output stalls
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |=> s1_valid_r && out_valid_r)
    else $error("pipeline dropped a beat under stall");

  // output valid only drops after the beat was taken
  a_out_taken: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_tready))
    else $error("output beat withdrawn");

endmodule

`default_nettype wire

FILE: hw/rtl/cmil_ram.sv
`default_nettype none

module cmil_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 65,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr_a,
  input  wire logic [ADDR_W-1:0] rd_addr_b,
  output logic      [DATA_W-1:0] rd_data_a,
  output logic      [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cmil_interp.sv
`default_nettype none

module cmil_interp (
  input  wire cmil_pkg::interp_in_t        in,
  output logic [cmil_pkg::CHAN_W-1:0]      chan
);

  import cmil_pkg::*;

  logic signed [ENTRY_W:0]         diff;
  logic signed [ENTRY_W+FRAC_W+1:0] prod;
  logic signed [ENTRY_W+FRAC_W+2:0] num;
  logic [ENTRY_W+FRAC_W+1-16:0]    whole;

  always_comb begin
    diff  = $signed({1'b0, in.e1}) - $signed({1'b0, in.e0});
    prod  = diff * $signed({1'b0, in.fr});
    num   = $signed({3'b000, in.e0, {FRAC_W{1'b0}}}) + (ENTRY_W+FRAC_W+3)'(prod);
    whole = num[ENTRY_W+FRAC_W+1:16];
    // value lies between the entries, so the negative arm is only a guard
    if (num[ENTRY_W+FRAC_W+2]) begin
      chan = '0;
    end else if (whole > (ENTRY_W+FRAC_W+2-16)'(255)) begin
      chan = '1;
    end else begin
      chan = whole[CHAN_W-1:0];
    end
  end

endmodule

`default_nettype wire
